>>> design/s2cd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_pkg
// Types, constants and the microcode program for the seconds-to-calendar
// converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

    localparam int unsigned StepW = 4;
    typedef logic [StepW-1:0] step_t;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_YEAR  = 3'd4,
        OP_MONTH = 3'd5,
        OP_EMIT  = 3'd6
    } op_t;

    typedef enum logic {
        DSEL_60 = 1'b0,
        DSEL_24 = 1'b1
    } dsel_t;

    typedef enum logic [1:0] {
        DST_SEC  = 2'd0,
        DST_MIN  = 2'd1,
        DST_HR   = 2'd2
    } dst_t;

    typedef enum logic [2:0] {
        COND_NONE        = 3'd0,
        COND_NO_INPUT    = 3'd1,
        COND_YEAR_FITS   = 3'd2,
        COND_MONTH_FITS  = 3'd3,
        COND_OUT_BUSY    = 3'd4,
        COND_ALWAYS      = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
        dst_t  dst;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam step_t StepWait  = 4'd0;
    localparam step_t StepYear  = 4'd7;
    localparam step_t StepMonth = 4'd8;
    localparam step_t StepEmit  = 4'd9;
    localparam step_t StepLast  = 4'd9;

    // Reciprocal constants: x / 60 = (x * K60) >> 37 and x / 24 = (x * K24) >> 36
    // hold exactly for every 32-bit x.
    localparam logic [31:0] Recip60 = 32'h8888_8889;
    localparam logic [31:0] Recip24 = 32'hAAAA_AAAB;
    localparam logic [5:0]  Div60   = 6'd60;
    localparam logic [5:0]  Div24   = 6'd24;

    localparam logic [11:0] EpochYear   = 12'd2000;
    localparam logic [7:0]  CenturyOff  = 8'd100;
    localparam logic [3:0]  MonthFirst  = 4'd1;
    localparam logic [3:0]  MonthLast   = 4'd12;
    localparam logic [8:0]  LeapYearLen = 9'd366;
    localparam logic [8:0]  YearLen     = 9'd365;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        unique case (step)
            4'd0:    w = '{OP_LOAD,  DSEL_60, DST_SEC, COND_NO_INPUT,   StepWait};
            4'd1:    w = '{OP_MUL,   DSEL_60, DST_SEC, COND_NONE,       StepWait};
            4'd2:    w = '{OP_DIV,   DSEL_60, DST_SEC, COND_NONE,       StepWait};
            4'd3:    w = '{OP_MUL,   DSEL_60, DST_MIN, COND_NONE,       StepWait};
            4'd4:    w = '{OP_DIV,   DSEL_60, DST_MIN, COND_NONE,       StepWait};
            4'd5:    w = '{OP_MUL,   DSEL_24, DST_HR,  COND_NONE,       StepWait};
            4'd6:    w = '{OP_DIV,   DSEL_24, DST_HR,  COND_NONE,       StepWait};
            4'd7:    w = '{OP_YEAR,  DSEL_60, DST_SEC, COND_YEAR_FITS,  StepYear};
            4'd8:    w = '{OP_MONTH, DSEL_60, DST_SEC, COND_MONTH_FITS, StepMonth};
            4'd9:    w = '{OP_EMIT,  DSEL_60, DST_SEC, COND_OUT_BUSY,   StepEmit};
            default: w = '{OP_NOP,   DSEL_60, DST_SEC, COND_ALWAYS,     StepWait};
        endcase
        return w;
    endfunction

endpackage

>>> design/seconds_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts a count of seconds since 2000-01-01 00:00:00 into year, month,
// day, hour, minute and second, driven by a small microcode program.
// ----------------------------------------------------------------------------
// Flow: the wait step takes an input, multiply and divide steps split off the
// seconds, minutes and hours, then the year and month steps run one per cycle,
// one per whole year past 2000 (at most 136) and one per whole month past
// January (at most 11), and the emit step writes the result, waiting while the
// output is busy. No new input is taken until the word before has been emitted;
// the output register holds a finished word while the next input is taken.
// Reset: aresetn (synchronous) returns the step counter to the wait step and
// clears m_valid.
module seconds_to_calendar_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_elapsed_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);

    s2cd_pkg::step_t  pc_reg, pc_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      acc_reg, acc_next;
    logic [63:0]      prod_reg, prod_next;
    logic [5:0]       sec_reg, sec_next;
    logic [5:0]       min_reg, min_next;
    logic [4:0]       hr_reg, hr_next;
    logic [15:0]      days_reg, days_next;
    logic [7:0]       yoff_reg, yoff_next;
    logic [3:0]       mon_reg, mon_next;
    logic [11:0]      o_year_reg, o_year_next;
    logic [3:0]       o_month_reg, o_month_next;
    logic [4:0]       o_day_reg, o_day_next;
    logic [4:0]       o_hour_reg, o_hour_next;
    logic [5:0]       o_min_reg, o_min_next;
    logic [5:0]       o_sec_reg, o_sec_next;

    s2cd_pkg::uword_t uw;
    logic             leap;
    logic [8:0]       ylen;
    logic [4:0]       mlen;
    logic             year_fits;
    logic             month_fits;
    logic             out_busy;
    logic             jump;
    logic [31:0]      recip;
    logic [5:0]       divisor;
    logic [31:0]      quo;
    logic [31:0]      rem;

    always_comb begin
        uw         = s2cd_pkg::ucode(pc_reg);
        leap       = (yoff_reg[1:0] == 2'd0) && (yoff_reg != s2cd_pkg::CenturyOff);
        ylen       = leap ? s2cd_pkg::LeapYearLen : s2cd_pkg::YearLen;
        mlen       = s2cd_pkg::month_len(mon_reg, leap);
        year_fits  = days_reg >= {7'd0, ylen};
        month_fits = (mon_reg != s2cd_pkg::MonthLast) && (days_reg >= {11'd0, mlen});
        out_busy   = m_valid_reg && !m_ready;

        if (uw.dsel == s2cd_pkg::DSEL_60) begin
            recip   = s2cd_pkg::Recip60;
            divisor = s2cd_pkg::Div60;
            quo     = {5'd0, prod_reg[63:37]};
        end else begin
            recip   = s2cd_pkg::Recip24;
            divisor = s2cd_pkg::Div24;
            quo     = {4'd0, prod_reg[63:36]};
        end
        rem = acc_reg - 32'(quo * {26'd0, divisor});

        unique case (uw.cond)
            s2cd_pkg::COND_NONE:       jump = 1'b0;
            s2cd_pkg::COND_NO_INPUT:   jump = !s_valid;
            s2cd_pkg::COND_YEAR_FITS:  jump = year_fits;
            s2cd_pkg::COND_MONTH_FITS: jump = month_fits;
            s2cd_pkg::COND_OUT_BUSY:   jump = out_busy;
            s2cd_pkg::COND_ALWAYS:     jump = 1'b1;
            default:                   jump = 1'b1;
        endcase

        if (jump) begin
            pc_next = uw.target;
        end else if (pc_reg == s2cd_pkg::StepLast) begin
            pc_next = s2cd_pkg::StepWait;
        end else begin
            pc_next = pc_reg + s2cd_pkg::step_t'(1);
        end

        acc_next     = acc_reg;
        prod_next    = prod_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hr_next      = hr_reg;
        days_next    = days_reg;
        yoff_next    = yoff_reg;
        mon_next     = mon_reg;
        o_year_next  = o_year_reg;
        o_month_next = o_month_reg;
        o_day_next   = o_day_reg;
        o_hour_next  = o_hour_reg;
        o_min_next   = o_min_reg;
        o_sec_next   = o_sec_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (uw.op)
            s2cd_pkg::OP_LOAD: begin
                if (s_valid) begin
                    acc_next  = s_elapsed_seconds;
                    yoff_next = 8'd0;
                    mon_next  = s2cd_pkg::MonthFirst;
                end
            end
            s2cd_pkg::OP_MUL: begin
                prod_next = {32'd0, acc_reg} * {32'd0, recip};
            end
            s2cd_pkg::OP_DIV: begin
                acc_next = quo;
                unique case (uw.dst)
                    s2cd_pkg::DST_SEC: sec_next = rem[5:0];
                    s2cd_pkg::DST_MIN: min_next = rem[5:0];
                    s2cd_pkg::DST_HR: begin
                        hr_next   = rem[4:0];
                        days_next = quo[15:0];
                    end
                    default: ;
                endcase
            end
            s2cd_pkg::OP_YEAR: begin
                if (year_fits) begin
                    days_next = days_reg - {7'd0, ylen};
                    yoff_next = yoff_reg + 8'd1;
                end
            end
            s2cd_pkg::OP_MONTH: begin
                if (month_fits) begin
                    days_next = days_reg - {11'd0, mlen};
                    mon_next  = mon_reg + 4'd1;
                end
            end
            s2cd_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    o_year_next  = s2cd_pkg::EpochYear + {4'd0, yoff_reg};
                    o_month_next = mon_reg;
                    o_day_next   = days_reg[4:0] + 5'd1;
                    o_hour_next  = hr_reg;
                    o_min_next   = min_reg;
                    o_sec_next   = sec_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= s2cd_pkg::StepWait;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hr_reg      <= hr_next;
        days_reg    <= days_next;
        yoff_reg    <= yoff_next;
        mon_reg     <= mon_next;
        o_year_reg  <= o_year_next;
        o_month_reg <= o_month_next;
        o_day_reg   <= o_day_next;
        o_hour_reg  <= o_hour_next;
        o_min_reg   <= o_min_next;
        o_sec_reg   <= o_sec_next;
    end

    assign s_ready        = (pc_reg == s2cd_pkg::StepWait);
    assign m_valid        = m_valid_reg;
    assign m_year         = o_year_reg;
    assign m_month        = o_month_reg;
    assign m_day_of_month = o_day_reg;
    assign m_hour         = o_hour_reg;
    assign m_minute       = o_min_reg;
    assign m_second       = o_sec_reg;

endmodule
